// File: src/ssr_pkg.sv
`default_nettype none

package ssr_pkg;

   localparam int unsigned MaxPatternDefault = 8;
   localparam int unsigned ByteW             = 8;
   localparam int unsigned LenW              = 4;
   localparam int unsigned CfgDataW          = 64;
   localparam int unsigned CsrAddrW          = 5;
   localparam int unsigned ReplMax           = 8;
   localparam int unsigned ReplIdxW          = $clog2(ReplMax);

   typedef enum logic [1:0] {
      REG_MATCH_PATTERN      = 2'd0,
      REG_PATTERN_LENGTH     = 2'd1,
      REG_REPLACEMENT_TEXT   = 2'd2,
      REG_REPLACEMENT_LENGTH = 2'd3
   } ssr_reg_type;

   typedef struct packed {
      logic [ByteW-1:0] in_byte;
      logic             final_byte;
   } ssr_req_type;

   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             byte_valid;
      logic             run_last;
      logic             string_end;
   } ssr_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EVAL = 2'd1,
      ST_REPL = 2'd2
   } ssr_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;          // take the input byte into the window
      logic drop;          // emit front byte, shift window
      logic repl_emit;     // emit next replacement byte
      logic clear_window;  // window empties after a match
      logic finish;        // close the transfer run of this item
   } ssr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic cnt_zero;
      logic full_match;
      logic partial;
      logic fin;
      logic can_emit;
      logic can_finish;
      logic repl_last;
      logic rlen_zero;
   } ssr_status_type;

endpackage

`default_nettype wire

// File: src/stream_substring_replace_unit.sv
// Flow: an item is accepted, then evaluated; each byte emitted from the window, each match
//   and each replacement byte takes its own sequencer step, and output stalls hold the
//   sequencer; a new byte waits for the run to close. The single result port sets the pace.
// Output path: the last transfer of an item enters the output register as its evaluate
//   step closes the run; earlier transfers wait in a hold stage for the next emission.
// Reset: synchronous, active high; clears config registers, state, window count, hold and output valid.
`default_nettype none

module stream_substring_replace_unit import ssr_pkg::*; #(
   parameter int unsigned MAX_PATTERN = MaxPatternDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // input stream, one source byte per transfer
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire ssr_req_type         req_data,
   // output stream, one rewritten byte (or the empty end marker) per transfer
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output ssr_rsp_type              rsp_data,
   // register port, 64-bit data, registers at byte address 8*i
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [CfgDataW-1:0] csr_pwdata,
   output logic      [CfgDataW-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [CfgDataW-1:0] match_pattern;
   logic [LenW-1:0]     pattern_length;
   logic [CfgDataW-1:0] replacement_text;
   logic [LenW-1:0]     replacement_length;
   ssr_cmd_type         cmd;
   ssr_status_type      status;

   // configuration registers; the user must write them only while the block is idle (not enforced here)
   ssr_csr u_csr (
      .clock              (clock),
      .reset              (reset),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .match_pattern      (match_pattern),
      .pattern_length     (pattern_length),
      .replacement_text   (replacement_text),
      .replacement_length (replacement_length)
   );

   // sequencer: accept, then evaluate / drop / replace one step per cycle while the output does not stall
   ssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // waiting-byte window, prefix compare, hold stage and output register
   ssr_datapath #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_data           (req_data),
      .match_pattern      (match_pattern),
      .pattern_length     (pattern_length),
      .replacement_text   (replacement_text),
      .replacement_length (replacement_length),
      .cmd                (cmd),
      .status             (status),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_data           (rsp_data)
   );

endmodule

`default_nettype wire

// File: src/ssr_csr.sv
`default_nettype none

module ssr_csr import ssr_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [CfgDataW-1:0] csr_pwdata,
   output logic      [CfgDataW-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic      [CfgDataW-1:0] match_pattern,
   output logic      [LenW-1:0]     pattern_length,
   output logic      [CfgDataW-1:0] replacement_text,
   output logic      [LenW-1:0]     replacement_length
);

   logic [CfgDataW-1:0] pattern_ff, pattern_in;
   logic [LenW-1:0]     plen_ff, plen_in;
   logic [CfgDataW-1:0] repl_ff, repl_in;
   logic [LenW-1:0]     rlen_ff, rlen_in;
   logic                wr_en;
   ssr_reg_type         reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = ssr_reg_type'(csr_paddr[CsrAddrW-1:CsrAddrW-2]);

   always_comb begin
      pattern_in = pattern_ff;
      plen_in    = plen_ff;
      repl_in    = repl_ff;
      rlen_in    = rlen_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_MATCH_PATTERN:      pattern_in = csr_pwdata;
            REG_PATTERN_LENGTH:     plen_in    = csr_pwdata[LenW-1:0];
            REG_REPLACEMENT_TEXT:   repl_in    = csr_pwdata;
            REG_REPLACEMENT_LENGTH: rlen_in    = csr_pwdata[LenW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MATCH_PATTERN:      csr_prdata = pattern_ff;
         REG_PATTERN_LENGTH:     csr_prdata = CfgDataW'(plen_ff);
         REG_REPLACEMENT_TEXT:   csr_prdata = repl_ff;
         REG_REPLACEMENT_LENGTH: csr_prdata = CfgDataW'(rlen_ff);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         plen_ff    <= '0;
         repl_ff    <= '0;
         rlen_ff    <= '0;
      end else begin
         pattern_ff <= pattern_in;
         plen_ff    <= plen_in;
         repl_ff    <= repl_in;
         rlen_ff    <= rlen_in;
      end
   end

   assign match_pattern      = pattern_ff;
   assign pattern_length     = plen_ff;
   assign replacement_text   = repl_ff;
   assign replacement_length = rlen_ff;

endmodule

`default_nettype wire

// File: src/ssr_ctrl.sv
`default_nettype none

module ssr_ctrl import ssr_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire ssr_status_type status,
   output ssr_cmd_type         cmd
);

   ssr_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!status.cnt_zero && status.full_match) begin
               if (!status.rlen_zero) state_in = ST_REPL;
            end else if (!status.cnt_zero && (!status.partial || status.fin)) begin
               state_in = ST_EVAL;
            end else if (status.can_finish) begin
               state_in = ST_IDLE;
            end
         end
         ST_REPL: begin
            if (status.can_emit && status.repl_last) state_in = ST_EVAL;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EVAL: begin
            if (!status.cnt_zero && status.full_match) begin
               cmd.clear_window = status.rlen_zero;
            end else if (!status.cnt_zero && (!status.partial || status.fin)) begin
               // mismatch, or flush at end of string
               cmd.drop = status.can_emit;
            end else begin
               cmd.finish = status.can_finish;
            end
         end
         ST_REPL: begin
            if (status.can_emit) begin
               cmd.repl_emit    = 1'b1;
               cmd.clear_window = status.repl_last;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: src/ssr_datapath.sv
`default_nettype none

module ssr_datapath import ssr_pkg::*; #(
   parameter int unsigned MAX_PATTERN = MaxPatternDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ssr_req_type         req_data,
   input  wire logic [CfgDataW-1:0] match_pattern,
   input  wire logic [LenW-1:0]     pattern_length,
   input  wire logic [CfgDataW-1:0] replacement_text,
   input  wire logic [LenW-1:0]     replacement_length,
   input  wire ssr_cmd_type         cmd,
   output ssr_status_type           status,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output ssr_rsp_type              rsp_data
);

   localparam int unsigned CNT_W = $clog2(MAX_PATTERN + 1);

   logic [ByteW-1:0]    win_ff [MAX_PATTERN];
   logic [ByteW-1:0]    win_in [MAX_PATTERN];
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                fin_ff, fin_in;
   logic [ReplIdxW-1:0] idx_ff, idx_in;
   ssr_rsp_type         hold_ff, hold_in;
   logic                hold_valid_ff, hold_valid_in;
   ssr_rsp_type         rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]    plen_eff;
   logic [LenW-1:0]     rlen_eff;
   logic                prefix_ok;
   logic                win_full;
   logic                slot_free;
   logic                emit;
   logic [ByteW-1:0]    emit_byte;
   logic                push;

   assign plen_eff  = (pattern_length > LenW'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN)
                                                            : pattern_length[CNT_W-1:0];
   assign rlen_eff  = (replacement_length > LenW'(ReplMax)) ? LenW'(ReplMax)
                                                             : replacement_length;
   assign win_full  = (cnt_ff == CNT_W'(MAX_PATTERN));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // every waiting byte agrees with the pattern at its place
   always_comb begin
      prefix_ok = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (CNT_W'(i) < cnt_ff && win_ff[i] != match_pattern[i*ByteW +: ByteW])
            prefix_ok = 1'b0;
      end
   end

   // window, count and replacement index
   always_comb begin
      win_in    = win_ff;
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      idx_in    = idx_ff;
      emit      = 1'b0;
      emit_byte = win_ff[0];
      if (cmd.load) begin
         fin_in = req_data.final_byte;
         idx_in = '0;
         if (win_full) begin
            emit = 1'b1;
            for (int i = 0; i < MAX_PATTERN - 1; i++) win_in[i] = win_ff[i+1];
            win_in[MAX_PATTERN-1] = req_data.in_byte;
         end else begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
               if (cnt_ff == CNT_W'(i)) win_in[i] = req_data.in_byte;
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.drop) begin
         emit = 1'b1;
         for (int i = 0; i < MAX_PATTERN - 1; i++) win_in[i] = win_ff[i+1];
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (cmd.repl_emit) begin
         emit      = 1'b1;
         emit_byte = replacement_text[idx_ff*ByteW +: ByteW];
         idx_in    = idx_ff + ReplIdxW'(1);
      end
      if (cmd.clear_window) cnt_in = '0;
   end

   // one-deep hold keeps the newest result until we know whether it ends the run
   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      push          = 1'b0;
      if (emit) begin
         if (hold_valid_ff) begin
            rsp_in = hold_ff;
            push   = 1'b1;
         end
         hold_in.out_byte   = emit_byte;
         hold_in.byte_valid = 1'b1;
         hold_in.run_last   = 1'b0;
         hold_in.string_end = 1'b0;
         hold_valid_in      = 1'b1;
      end
      if (cmd.finish) begin
         if (hold_valid_ff) begin
            rsp_in            = hold_ff;
            rsp_in.run_last   = 1'b1;
            rsp_in.string_end = fin_ff;
            push              = 1'b1;
            hold_valid_in     = 1'b0;
         end else if (fin_ff) begin
            rsp_in.out_byte   = '0;
            rsp_in.byte_valid = 1'b0;
            rsp_in.run_last   = 1'b1;
            rsp_in.string_end = 1'b1;
            push              = 1'b1;
         end
      end
      rsp_valid_in = push || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      fin_ff  <= fin_in;
      idx_ff  <= idx_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign status.cnt_zero   = (cnt_ff == '0);
   assign status.full_match = (cnt_ff != '0) && (cnt_ff == plen_eff) && prefix_ok;
   assign status.partial    = (cnt_ff < plen_eff) && prefix_ok;
   assign status.fin        = fin_ff;
   assign status.can_emit   = !hold_valid_ff || slot_free;
   assign status.can_finish = slot_free || (!hold_valid_ff && !fin_ff);
   assign status.repl_last  = ((LenW'(idx_ff) + LenW'(1)) == rlen_eff);
   assign status.rlen_zero  = (rlen_eff == '0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_PATTERN))
      else $error("window count beyond depth");

   a_load_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cnt_ff != '0)
      else $error("window empty after load");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push && rsp_valid_ff |-> rsp_ready)
      else $error("output register overwritten while stalled");

   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && !hold_valid_ff && fin_ff |=>
         rsp_valid_ff && rsp_ff.string_end && !rsp_ff.byte_valid)
      else $error("missing empty end marker");

endmodule

`default_nettype wire

// File: test/stream_substring_replace_unit_tb.sv
`timescale 1ns / 100ps

module stream_substring_replace_unit_tb;
   import ssr_pkg::*;

   // Cycles with no transfer on either stream before the run is declared hung.
   // The worst quiet stretch is the long output hold plus a config pause.
   localparam int unsigned WatchdogLimit    = 3000;
   // Quiet cycles after the last expected transfer before registers change:
   // an item that leaves its byte waiting produces nothing, but still needs
   // its accept and evaluate cycles.
   localparam int unsigned SettleCycles     = 16;
   localparam int unsigned LongHoldCycles   = 400;
   localparam int unsigned RandomItemTarget = 360;
   localparam int unsigned ReportLimit      = 10;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   ssr_req_type         req_data    = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   ssr_rsp_type         rsp_data;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr   = '0;
   logic [CfgDataW-1:0] csr_pwdata  = '0;
   logic [CfgDataW-1:0] csr_prdata;
   logic                csr_pready;

   // Shadow of the register file, updated at the edge each write lands.
   logic [63:0] cfg_pattern = '0;
   logic [3:0]  cfg_plen    = '0;
   logic [63:0] cfg_repl    = '0;
   logic [3:0]  cfg_rlen    = '0;

   // Shadow of the block's look-ahead window: bytes that may still start a match.
   logic [7:0]  held_bytes [MaxPatternDefault];
   int          held_count = 0;

   ssr_req_type source_bytes [$];     // bytes waiting for the driver
   ssr_rsp_type rewrite_expected [$]; // predicted output transfers, oldest first
   logic [7:0]  text_buf [$];         // string under construction

   int          bytes_queued      = 0;
   int          bytes_accepted    = 0;
   int          transfers_checked = 0;
   int          mismatch_count    = 0;
   int          match_hits        = 0;
   int          strings_closed    = 0;
   int          reg_writes        = 0;
   int          random_items      = 0;
   int          idle_cycles       = 0;
   bit          string_open       = 1'b0;
   bit          random_phase_on   = 1'b0;

   // sender burst state
   int          burst_left = 1;
   int          gap_left   = 0;

   // receiver stall state
   logic [7:0]  ready_mask     = 8'hFF;
   int          mask_age       = 0;
   int          hold_left      = 0;
   bit          long_hold_done = 1'b0;

   ssr_rsp_type next_want;

   stream_substring_replace_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Rewrite predictor
   // ---------------------------------------------------------------------

   function automatic void push_out(logic [7:0] b, logic carries_byte);
      ssr_rsp_type r;
      r.out_byte   = b;
      r.byte_valid = carries_byte;
      r.run_last   = 1'b0;
      r.string_end = 1'b0;
      rewrite_expected.push_back(r);
   endfunction

   // Front byte of the window goes out; the rest slide down.
   function automatic void emit_front();
      push_out(held_bytes[0], 1'b1);
      for (int i = 1; i < held_count; i++)
         held_bytes[i-1] = held_bytes[i];
      held_count--;
   endfunction

   function automatic bit held_is_prefix();
      for (int i = 0; i < held_count; i++)
         if (held_bytes[i] != cfg_pattern[8*i +: 8])
            return 1'b0;
      return 1'b1;
   endfunction

   // Works out every transfer caused by one source byte and queues them.
   function automatic void predict_rewrite(ssr_req_type item);
      int          plen;
      int          rlen;
      int          base;
      ssr_rsp_type tail;
      plen = (cfg_plen > MaxPatternDefault) ? MaxPatternDefault : cfg_plen;
      rlen = (cfg_rlen > ReplMax) ? ReplMax : cfg_rlen;
      base = rewrite_expected.size();

      // a full window makes room first (unreachable with legal lengths)
      if (held_count == MaxPatternDefault)
         emit_front();
      held_bytes[held_count] = item.in_byte;
      held_count++;

      while (held_count > 0) begin
         if (held_count == plen && held_is_prefix()) begin
            for (int i = 0; i < rlen; i++)
               push_out(cfg_repl[8*i +: 8], 1'b1);
            held_count = 0;
            match_hits++;
         end else if (held_count < plen && held_is_prefix()) begin
            break;
         end else begin
            emit_front();
         end
      end

      if (item.final_byte) begin
         while (held_count > 0)
            emit_front();
         // an empty rewrite still owes the consumer an end marker
         if (rewrite_expected.size() == base)
            push_out(8'h00, 1'b0);
         tail = rewrite_expected.pop_back();
         tail.string_end = 1'b1;
         rewrite_expected.push_back(tail);
      end
      if (rewrite_expected.size() > base) begin
         tail = rewrite_expected.pop_back();
         tail.run_last = 1'b1;
         rewrite_expected.push_back(tail);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Source driver: bursts of random length separated by random gaps.
   // Once valid is up it holds with the same byte until the transfer.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_rewrite(req_data);
            bytes_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (source_bytes.size() > 0) begin
               req_data  <= source_bytes.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result receiver: a rotating ready mask, reloaded whenever its age counter wraps
   // (a quarter of the time all ones, so some stretches never stall).
   // Early in the random part it holds off for LongHoldCycles so the
   // block backs up and has to stall the source side.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (random_phase_on && !long_hold_done && rsp_valid) begin
            hold_left      = LongHoldCycles;
            long_hold_done = 1'b1;
         end
         if (mask_age == 63) begin
            mask_age   = 0;
            ready_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
         end else begin
            mask_age++;
            ready_mask = {ready_mask[0], ready_mask[7:1]};
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ready_mask[0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: every transfer is checked against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (rewrite_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
               $display("unexpected transfer: byte %02h valid %b last %b end %b",
                        rsp_data.out_byte, rsp_data.byte_valid,
                        rsp_data.run_last, rsp_data.string_end);
         end else begin
            next_want = rewrite_expected.pop_front();
            transfers_checked++;
            if (rsp_data.out_byte   !== next_want.out_byte   ||
                rsp_data.byte_valid !== next_want.byte_valid ||
                rsp_data.run_last   !== next_want.run_last   ||
                rsp_data.string_end !== next_want.string_end) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit) begin
                  $display("transfer %0d: expected byte %02h valid %b last %b end %b",
                           transfers_checked,
                           next_want.out_byte, next_want.byte_valid,
                           next_want.run_last, next_want.string_end);
                  $display("   got byte %02h valid %b last %b end %b",
                           rsp_data.out_byte, rsp_data.byte_valid,
                           rsp_data.run_last, rsp_data.string_end);
               end
            end
         end
      end
   end

   // Watchdog: resets on any transfer, fires after a long quiet stretch.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Register write: setup cycle, then access cycle until pready.
   task automatic write_reg(ssr_reg_type idx, logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrW'({idx, 3'b000});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_MATCH_PATTERN:      cfg_pattern = value;
         REG_PATTERN_LENGTH:     cfg_plen    = value[3:0];
         REG_REPLACEMENT_TEXT:   cfg_repl    = value;
         REG_REPLACEMENT_LENGTH: cfg_rlen    = value[3:0];
      endcase
      reg_writes++;
   endtask

   // Hands text_buf to the driver; the last byte closes the string unless
   // the string is to stay open across a register change.
   task automatic queue_text(bit leave_open);
      ssr_req_type item;
      foreach (text_buf[i]) begin
         item.in_byte    = text_buf[i];
         item.final_byte = (i == text_buf.size() - 1) && !leave_open;
         source_bytes.push_back(item);
         bytes_queued++;
      end
      if (!leave_open)
         strings_closed++;
      string_open = leave_open;
   endtask

   // Block is idle: all bytes taken, all results seen, plus a margin for
   // bytes that only went into the window.
   task automatic settle_block();
      while (bytes_accepted != bytes_queued || rewrite_expected.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // One random setting followed by strings built mostly from pieces of
   // the pattern, so that matches, near-misses and overlaps are common.
   task automatic run_random_phase();
      logic [63:0] noise;
      logic [63:0] pat;
      logic [7:0]  base;
      bit          narrow;
      bit          leave_open;
      int          len_pick;
      int          rlen_pick;
      int          plen_eff;
      int          target;
      int          phase_items;
      int          text_len;
      int          piece;
      int          cut;

      // narrow alphabets make self-overlapping patterns likely
      narrow = $urandom_range(0, 2) != 0;
      base   = 8'($urandom);
      for (int i = 0; i < 8; i++)
         pat[8*i +: 8] = narrow ? 8'(base + $urandom_range(0, 1)) : 8'($urandom);
      case ($urandom_range(0, 9))
         0:       len_pick = 0;
         1:       len_pick = $urandom_range(9, 15);
         default: len_pick = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
         0:       rlen_pick = 0;
         1:       rlen_pick = $urandom_range(9, 15);
         default: rlen_pick = $urandom_range(1, 8);
      endcase

      // length registers get junk above bit 3, which the block must drop
      write_reg(REG_MATCH_PATTERN, pat);
      noise = {$urandom, $urandom};
      write_reg(REG_PATTERN_LENGTH, {noise[63:4], 4'(len_pick)});
      write_reg(REG_REPLACEMENT_TEXT, {$urandom, $urandom});
      noise = {$urandom, $urandom};
      write_reg(REG_REPLACEMENT_LENGTH, {noise[63:4], 4'(rlen_pick)});

      plen_eff    = (cfg_plen > MaxPatternDefault) ? MaxPatternDefault : cfg_plen;
      target      = $urandom_range(30, 55);
      phase_items = 0;
      while (phase_items < target) begin
         text_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                : $urandom_range(1, 12);
         text_buf.delete();
         while (text_buf.size() < text_len) begin
            piece = $urandom_range(0, 9);
            if (piece < 7 && plen_eff > 0) begin
               // whole pattern, or a prefix broken by a stray byte
               cut = (piece < 5) ? plen_eff : $urandom_range(0, plen_eff - 1);
               for (int i = 0; i < cut; i++)
                  text_buf.push_back(cfg_pattern[8*i +: 8]);
               if (piece >= 5)
                  text_buf.push_back(narrow ? 8'(base + $urandom_range(0, 2)) : 8'($urandom));
            end else if (piece != 9) begin
               text_buf.push_back(narrow ? 8'(base + $urandom_range(0, 2)) : 8'($urandom));
            end else begin
               text_buf.push_back(8'($urandom));
            end
         end
         // the last string of a phase may stay open into the next setting
         leave_open = (phase_items + text_buf.size() >= target) && ($urandom_range(0, 2) == 0);
         queue_text(leave_open);
         phase_items  += text_buf.size();
         random_items += text_buf.size();
      end
      settle_block();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Copy mode straight out of reset; extreme byte values, zero is ordinary.
      text_buf = '{8'hFF, 8'h00};
      queue_text(1'b0);
      settle_block();

      // "aba" -> "<>": one match, then "b" passes and the tail "a" is flushed at the end.
      write_reg(REG_MATCH_PATTERN, 64'h0000_0000_0061_6261);
      write_reg(REG_PATTERN_LENGTH, 64'd3);
      write_reg(REG_REPLACEMENT_TEXT, 64'h0000_0000_0000_3E3C);
      write_reg(REG_REPLACEMENT_LENGTH, 64'd2);
      text_buf = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h61};
      queue_text(1'b0);
      settle_block();

      // Oversized pattern length saturates to 8; deletion on the final byte
      // leaves nothing, so only the empty end marker comes out.
      write_reg(REG_MATCH_PATTERN, 64'h00FF_7E81_00FF_7E81);
      write_reg(REG_PATTERN_LENGTH, 64'd15);
      write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
      text_buf = '{8'h81, 8'h7E, 8'hFF, 8'h00, 8'h81, 8'h7E, 8'hFF, 8'h00};
      queue_text(1'b0);
      settle_block();

      // Pattern swapped while "ab" waits: the stale bytes spill once the
      // next byte arrives. Oversized replacement length saturates to 8.
      write_reg(REG_MATCH_PATTERN, 64'h0000_0000_0061_6261);
      write_reg(REG_PATTERN_LENGTH, 64'd3);
      write_reg(REG_REPLACEMENT_TEXT, 64'hF0E1_D2C3_B4A5_9687);
      write_reg(REG_REPLACEMENT_LENGTH, 64'd15);
      text_buf = '{8'h61, 8'h62};
      queue_text(1'b1);
      settle_block();
      write_reg(REG_MATCH_PATTERN, 64'h0000_0000_0000_7861);
      write_reg(REG_PATTERN_LENGTH, 64'd2);
      text_buf = '{8'h61, 8'h78};
      queue_text(1'b0);
      settle_block();

      // Drop to copy mode with bytes waiting: they go out ahead of the new one.
      write_reg(REG_MATCH_PATTERN, 64'h0000_0000_0061_6261);
      write_reg(REG_PATTERN_LENGTH, 64'd3);
      text_buf = '{8'h61, 8'h62};
      queue_text(1'b1);
      settle_block();
      write_reg(REG_PATTERN_LENGTH, 64'd0);
      text_buf = '{8'h63};
      queue_text(1'b0);
      settle_block();

      // Random settings and strings.
      random_phase_on = 1'b1;
      while (random_items < RandomItemTarget)
         run_random_phase();
      if (string_open) begin
         text_buf = '{8'($urandom)};
         queue_text(1'b0);
      end
      settle_block();

      while (rewrite_expected.size() > 0) begin
         next_want = rewrite_expected.pop_front();
         mismatch_count++;
         if (mismatch_count <= ReportLimit)
            $display("missing transfer: expected byte %02h valid %b last %b end %b",
                     next_want.out_byte, next_want.byte_valid,
                     next_want.run_last, next_want.string_end);
      end

      $display("Covered %0d source bytes in %0d closed strings over %0d register writes",
               bytes_accepted, strings_closed, reg_writes);
      $display("Checked %0d output transfers, %0d pattern hits, %0d mismatches",
               transfers_checked, match_hits, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: stream_substring_replace_unit.f
src/ssr_pkg.sv
src/ssr_csr.sv
src/ssr_ctrl.sv
src/ssr_datapath.sv
src/stream_substring_replace_unit.sv
test/stream_substring_replace_unit_tb.sv
